// File: hw/rtl/fbpm_pkg.sv
// ----------------------------------------------------------------------------
// Frame buffer pool manager package
// Shared sizes, codes, word formats and controller commands for the pool.
// ----------------------------------------------------------------------------
package fbpm_pkg;

  localparam int SLOTS       = 8;
  localparam int FRAME_WORDS = 16;
  localparam int SAMPLE_BITS = 64;

  localparam int PTR_W    = $clog2(SLOTS);
  localparam int COUNT_W  = $clog2(SLOTS + 1);
  localparam int DEPTH    = SLOTS * FRAME_WORDS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int OP_W     = 3;
  localparam int SLOT_W   = 3;
  localparam int WIDX_W   = 4;
  localparam int DATA_W   = 64;
  localparam int CNT_FW   = 4;

  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE   = 3'd1;
  localparam logic [OP_W-1:0] OP_FETCH   = 3'd2;
  localparam logic [OP_W-1:0] OP_READ    = 3'd3;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_NO_FILLED = 2'd2,
    ST_FREE_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [SLOT_W-1:0] slot;
    logic [WIDX_W-1:0] word_index;
    logic [DATA_W-1:0] sample_in;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot_out;
    logic [DATA_W-1:0] sample_out;
    logic [CNT_FW-1:0] free_slots;
    logic [CNT_FW-1:0] filled_slots;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic mem_rd;
    logic load_rd;
  } cmd_t;

  typedef struct packed {
    logic is_read;
  } sts_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/fbpm_ctrl.sv
// ----------------------------------------------------------------------------
// Frame buffer pool manager controller
// Sequences one word at a time through capture, execute and store read.
// ----------------------------------------------------------------------------
module fbpm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  fbpm_pkg::sts_t sts_i,
  output fbpm_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RDATA
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.is_read) begin
          cmd_o.mem_rd = 1'b1;
          state_d      = S_RDATA;
        end else if (out_free) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_RDATA: begin
        if (out_free) begin
          cmd_o.load_rd = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hw/rtl/fbpm_datapath.sv
// ----------------------------------------------------------------------------
// Frame buffer pool manager datapath
// Holds the free and filled slot rings, their counts and the frame store.
// ----------------------------------------------------------------------------
module fbpm_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fbpm_pkg::in_item_t  in_data_i,
  output fbpm_pkg::out_item_t out_data_o,
  input  fbpm_pkg::cmd_t      cmd_i,
  output fbpm_pkg::sts_t      sts_o
);

  fbpm_pkg::in_item_t  item_q;
  fbpm_pkg::out_item_t res_q, res_d;

  logic [fbpm_pkg::SLOT_W-1:0]  free_ring_q [fbpm_pkg::SLOTS];
  logic [fbpm_pkg::SLOT_W-1:0]  filled_ring_q [fbpm_pkg::SLOTS];
  logic [fbpm_pkg::PTR_W-1:0]   free_head_q, free_head_d, free_tail_q, free_tail_d;
  logic [fbpm_pkg::PTR_W-1:0]   filled_head_q, filled_head_d, filled_tail_q, filled_tail_d;
  logic [fbpm_pkg::COUNT_W-1:0] free_count_q, free_count_d;
  logic [fbpm_pkg::COUNT_W-1:0] filled_count_q, filled_count_d;
  logic                         free_push, filled_push;

  logic [fbpm_pkg::SAMPLE_BITS-1:0] store_mem [fbpm_pkg::DEPTH];
  logic [fbpm_pkg::SAMPLE_BITS-1:0] rdata_q;
  logic                             rd_hit_q;
  logic [fbpm_pkg::ADDR_W-1:0]      addr;
  logic                             slot_ok, word_ok, store_we, store_re;

  assign slot_ok  = int'(item_q.slot) < fbpm_pkg::SLOTS;
  assign word_ok  = int'(item_q.word_index) < fbpm_pkg::FRAME_WORDS;
  assign addr     = fbpm_pkg::ADDR_W'(int'(item_q.slot) * fbpm_pkg::FRAME_WORDS
                                      + int'(item_q.word_index));
  assign store_we = cmd_i.exec && (item_q.opcode == fbpm_pkg::OP_WRITE) && slot_ok && word_ok;
  assign store_re = cmd_i.mem_rd && slot_ok && word_ok;

  assign sts_o.is_read = (item_q.opcode == fbpm_pkg::OP_READ);
  assign out_data_o    = res_q;

  always_comb begin
    free_head_d    = free_head_q;
    free_tail_d    = free_tail_q;
    free_count_d   = free_count_q;
    filled_head_d  = filled_head_q;
    filled_tail_d  = filled_tail_q;
    filled_count_d = filled_count_q;
    free_push      = 1'b0;
    filled_push    = 1'b0;
    res_d          = '0;
    res_d.status   = fbpm_pkg::ST_OK;
    case (item_q.opcode)
      fbpm_pkg::OP_ALLOC: begin
        if (free_count_q == '0) begin
          res_d.status = fbpm_pkg::ST_NO_FREE;
        end else begin
          res_d.slot_out = free_ring_q[free_head_q];
          free_head_d    = fbpm_pkg::ring_next(free_head_q);
          free_count_d   = free_count_q - 1'b1;
        end
      end
      fbpm_pkg::OP_WRITE: begin
        if (slot_ok && item_q.is_last &&
            (filled_count_q < fbpm_pkg::COUNT_W'(fbpm_pkg::SLOTS))) begin
          filled_push    = 1'b1;
          filled_tail_d  = fbpm_pkg::ring_next(filled_tail_q);
          filled_count_d = filled_count_q + 1'b1;
        end
      end
      fbpm_pkg::OP_FETCH: begin
        if (filled_count_q == '0) begin
          res_d.status = fbpm_pkg::ST_NO_FILLED;
        end else begin
          res_d.slot_out = filled_ring_q[filled_head_q];
          filled_head_d  = fbpm_pkg::ring_next(filled_head_q);
          filled_count_d = filled_count_q - 1'b1;
        end
      end
      fbpm_pkg::OP_RELEASE: begin
        if (slot_ok) begin
          if (free_count_q >= fbpm_pkg::COUNT_W'(fbpm_pkg::SLOTS)) begin
            res_d.status = fbpm_pkg::ST_FREE_FULL;
          end else begin
            free_push    = 1'b1;
            free_tail_d  = fbpm_pkg::ring_next(free_tail_q);
            free_count_d = free_count_q + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res_d.free_slots   = fbpm_pkg::CNT_FW'(free_count_d);
    res_d.filled_slots = fbpm_pkg::CNT_FW'(filled_count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fbpm_pkg::SLOTS; i++) begin
        free_ring_q[i] <= fbpm_pkg::SLOT_W'(i);
      end
      free_head_q    <= '0;
      free_tail_q    <= '0;
      free_count_q   <= fbpm_pkg::COUNT_W'(fbpm_pkg::SLOTS);
      filled_head_q  <= '0;
      filled_tail_q  <= '0;
      filled_count_q <= '0;
    end else if (cmd_i.exec) begin
      if (free_push) begin
        free_ring_q[free_tail_q] <= item_q.slot;
      end
      free_head_q    <= free_head_d;
      free_tail_q    <= free_tail_d;
      free_count_q   <= free_count_d;
      filled_head_q  <= filled_head_d;
      filled_tail_q  <= filled_tail_d;
      filled_count_q <= filled_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.exec && filled_push) begin
      filled_ring_q[filled_tail_q] <= item_q.slot;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end else if (cmd_i.load_rd) begin
      res_q.status       <= fbpm_pkg::ST_OK;
      res_q.slot_out     <= '0;
      res_q.sample_out   <= rd_hit_q ? fbpm_pkg::DATA_W'(rdata_q) : '0;
      res_q.free_slots   <= fbpm_pkg::CNT_FW'(free_count_q);
      res_q.filled_slots <= fbpm_pkg::CNT_FW'(filled_count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[addr] <= item_q.sample_in[fbpm_pkg::SAMPLE_BITS-1:0];
    end
    if (store_re) begin
      rdata_q <= store_mem[addr];
    end
    if (cmd_i.mem_rd) begin
      rd_hit_q <= store_re;
    end
  end

endmodule

// File: hw/rtl/frame_buffer_pool_manager.sv
// ----------------------------------------------------------------------------
// Frame buffer pool manager
// Hands out frame slots, queues filled frames and stores their sample words.
// ----------------------------------------------------------------------------
// Each input word carries one operation: alloc, write, fetch, read or release.
// Every input word produces exactly one output word on the result channel,
// with a status code, the popped slot id, the read sample and both ring
// occupancies after the operation.
// The input channel takes one word, then stays not ready while it executes.
// A write, alloc, fetch or release executes in the EXEC state once the
// output register is free, and its result is registered there; the next
// word is accepted when the controller is back in IDLE. A read also passes
// through the RDATA state for the registered port of the frame store.
// A finished result sits in an output register; the next word may be taken
// while it waits, but that word does not finish until the register is taken.
// After reset every slot is free, no slot is filled and the frame store
// holds no valid data.
// ----------------------------------------------------------------------------
module frame_buffer_pool_manager (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fbpm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fbpm_pkg::out_item_t out_data_o
);

  fbpm_pkg::cmd_t cmd;
  fbpm_pkg::sts_t sts;

  fbpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fbpm_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

// File: hw/rtl/fbpm_checker.sv
// ----------------------------------------------------------------------------
// Frame buffer pool manager checker
// Port-level properties of the pool manager, bound to the top level.
// ----------------------------------------------------------------------------
module fbpm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input fbpm_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Result word dropped or changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input accepted on two consecutive cycles.");

  a_no_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == fbpm_pkg::ST_NO_FREE)
      |-> out_data_o.free_slots == '0)
    else $error("No-free status reported with free slots left.");

  a_no_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == fbpm_pkg::ST_NO_FILLED)
      |-> out_data_o.filled_slots == '0)
    else $error("No-filled status reported with filled slots left.");

  a_free_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == fbpm_pkg::ST_FREE_FULL)
      |-> out_data_o.free_slots == fbpm_pkg::CNT_FW'(fbpm_pkg::SLOTS))
    else $error("Free-ring-full status reported with room left.");

endmodule

bind frame_buffer_pool_manager fbpm_checker u_fbpm_checker (.*);
